/* rtl/core/dpr_pkg.sv */
// Shared types, character codes and helpers for the debug packet receiver.
package dpr_pkg;

    // Framing phases
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_HEX1 = 2'd2,
        PH_HEX2 = 2'd3
    } phase_t;

    // Result group produced by one item
    typedef enum logic [1:0] {
        GRP_READ    = 2'd0,
        GRP_NAK     = 2'd1,
        GRP_ACK     = 2'd2,
        GRP_ACK_SEQ = 2'd3
    } grp_kind_t;

    // Result kind codes
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_READY = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] START_SEQ  = 2'd3;
    localparam logic [1:0] START_NONE = 2'd0;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ACK    = 8'h2B;
    localparam logic [7:0] CH_NAK    = 8'h2D;

    localparam int LEN_W = 11;

    // Result group queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        grp_kind_t          kind;
        logic               read_ok;
        logic [7:0]         seq0;
        logic [7:0]         seq1;
        logic [LEN_W-1:0]   len;
    } grp_t;

    typedef struct packed {
        grp_t       grp;
        logic [7:0] rdata;
    } q_entry_t;

    // Hex digit value; anything else counts as -1 modulo 256
    function automatic logic [7:0] hex_digit_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h61 + 8'd10;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h41 + 8'd10;
        else
            v = 8'hFF;
        return v;
    endfunction

endpackage

/* rtl/core/debug_packet_receiver_top.sv */
// Top level of the debug packet receiver.
// Usage:
//   Request channel (req_valid / req_stall): one item per handshake. With cmd
//   low, in_byte is one received link character; with cmd high, read_index
//   names a payload store entry to read back.
//   Response channel (rsp_valid / rsp_stall): result items in order; last
//   marks the final result caused by one request item.
//   A '$'...'#hh' packet gives '-' on a checksum mismatch, or '+', the two
//   sequence id characters when the payload starts with "xx:", and a
//   packet-ready item with payload_start and payload_length.
// The first result of an item is registered in the framer's descriptor register
//   and then in a queue entry before it is offered.
// Throughput: one request item per cycle while req_stall is low; the response
//   side drains one result per cycle while rsp_stall is low, from a four-group queue.
// The payload store is a single-port-write, registered-read memory; a read
//   item sees every byte written by earlier items.
// Reset clears the framing state and empties the queue; store contents are
//   undefined until written.
// When the receiver stalls, results wait in the queue; req_stall rises once
//   the queue cannot take another group.
module debug_packet_receiver_top #(
    parameter int STORE_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        cmd,
    input  logic [7:0]  in_byte,
    input  logic [10:0] read_index,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  kind,
    output logic [7:0]  tx_char,
    output logic [1:0]  payload_start,
    output logic [10:0] payload_length,
    output logic [7:0]  read_data,
    output logic        last
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic          accept;
    logic          ready;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          desc_valid;
    dpr_pkg::grp_t desc;

    assign req_stall = !ready;
    assign accept    = req_valid && ready;

    dpr_framer #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .in_byte    (in_byte),
        .read_index (read_index),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    dpr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dpr_result_queue u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (desc_valid),
        .push_grp       (desc),
        .push_rdata     (rd_data),
        .ready          (ready),
        .out_valid      (rsp_valid),
        .out_stall      (rsp_stall),
        .kind           (kind),
        .tx_char        (tx_char),
        .payload_start  (payload_start),
        .payload_length (payload_length),
        .read_data      (read_data),
        .last           (last)
    );

endmodule

/* rtl/core/dpr_store.sv */
// Payload store: one write port, one registered read port.
module dpr_store #(
    parameter int STORE_DEPTH = 2048,
    parameter int AW          = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/dpr_framer.sv */
// Packet framing state machine, checksum tracking and result group issue.
module dpr_framer #(
    parameter int STORE_DEPTH = 2048,
    parameter int AW          = 11
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           cmd,
    input  logic [7:0]     in_byte,
    input  logic [10:0]    read_index,
    output logic           wr_en,
    output logic [AW-1:0]  wr_addr,
    output logic [7:0]     wr_data,
    output logic           rd_en,
    output logic [AW-1:0]  rd_addr,
    output logic           desc_valid,
    output dpr_pkg::grp_t  desc
);

    dpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      rsum_reg, rsum_next;
    logic [AW-1:0]   count_reg, count_next;
    logic [7:0]      seq0_reg, seq0_next;
    logic [7:0]      seq1_reg, seq1_next;
    logic            colon_reg, colon_next;
    logic            desc_valid_reg, desc_valid_next;
    dpr_pkg::grp_t   desc_reg, desc_next;

    logic [AW:0]     count_inc;
    logic [AW+10:0]  idx_ext;
    logic [AW+10:0]  cnt_ext;
    logic [7:0]      hex;
    logic [7:0]      total;

    assign idx_ext   = (AW+11)'(read_index);
    assign cnt_ext   = (AW+11)'(count_reg);
    assign count_inc = {1'b0, count_reg} + (AW+1)'(1);
    assign hex       = dpr_pkg::hex_digit_val(in_byte);
    assign total     = rsum_reg + hex;

    assign wr_addr   = count_reg;
    assign wr_data   = in_byte;
    assign rd_addr   = idx_ext[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dpr_pkg::PH_HUNT;
            sum_reg        <= '0;
            rsum_reg       <= '0;
            count_reg      <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            sum_reg        <= sum_next;
            rsum_reg       <= rsum_next;
            count_reg      <= count_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    // first two payload bytes and whether the third is a colon, kept for the sequence id check, and the descriptor
    always_ff @(posedge clk)
    begin
        seq0_reg  <= seq0_next;
        seq1_reg  <= seq1_next;
        colon_reg <= colon_next;
        desc_reg  <= desc_next;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        sum_next        = sum_reg;
        rsum_next       = rsum_reg;
        count_next      = count_reg;
        seq0_next       = seq0_reg;
        seq1_next       = seq1_reg;
        colon_next      = colon_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        desc_valid_next = 1'b0;
        desc_next       = desc_reg;

        if (accept && cmd)
        begin
            rd_en             = 1'b1;
            desc_valid_next   = 1'b1;
            desc_next.kind    = dpr_pkg::GRP_READ;
            desc_next.read_ok = idx_ext < (AW+11)'(STORE_DEPTH);
        end
        else if (accept)
        begin
            case (phase_reg)
                dpr_pkg::PH_HUNT:
                begin
                    if (in_byte == dpr_pkg::CH_DOLLAR)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        phase_next = dpr_pkg::PH_DATA;
                    end
                end
                dpr_pkg::PH_DATA:
                begin
                    if (in_byte == dpr_pkg::CH_DOLLAR)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                    end
                    else if (in_byte == dpr_pkg::CH_HASH)
                    begin
                        phase_next = dpr_pkg::PH_HEX1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        sum_next = sum_reg + in_byte;
                        if (count_reg == AW'(0))
                            seq0_next = in_byte;
                        if (count_reg == AW'(1))
                            seq1_next = in_byte;
                        if (count_reg == AW'(2))
                            colon_next = (in_byte == dpr_pkg::CH_COLON);
                        // store full: drop the packet
                        if (count_inc >= (AW+1)'(STORE_DEPTH))
                        begin
                            count_next = '0;
                            sum_next   = '0;
                            phase_next = dpr_pkg::PH_HUNT;
                        end
                        else
                        begin
                            count_next = count_inc[AW-1:0];
                        end
                    end
                end
                dpr_pkg::PH_HEX1:
                begin
                    rsum_next  = {hex[3:0], 4'h0};
                    phase_next = dpr_pkg::PH_HEX2;
                end
                dpr_pkg::PH_HEX2:
                begin
                    rsum_next         = total;
                    phase_next        = dpr_pkg::PH_HUNT;
                    desc_valid_next   = 1'b1;
                    desc_next.read_ok = 1'b0;
                    desc_next.seq0    = seq0_reg;
                    desc_next.seq1    = seq1_reg;
                    desc_next.len     = cnt_ext[10:0];
                    if (total != sum_reg)
                        desc_next.kind = dpr_pkg::GRP_NAK;
                    else if (count_reg >= AW'(3) && colon_reg)
                        desc_next.kind = dpr_pkg::GRP_ACK_SEQ;
                    else
                        desc_next.kind = dpr_pkg::GRP_ACK;
                end
                default:
                begin
                    phase_next = dpr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (AW+1)'(count_reg) < (AW+1)'(STORE_DEPTH))
        else $error("byte count reached store depth");

    a_read_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd) |=> (phase_reg == $past(phase_reg) && count_reg == $past(count_reg)))
        else $error("read item changed framing state");

    a_drop_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dpr_pkg::PH_HUNT && $past(phase_reg) == dpr_pkg::PH_DATA)
        |-> (count_reg == '0 && sum_reg == 8'h00))
        else $error("overflow drop left stale count or sum");
`endif

endmodule

/* rtl/core/dpr_result_queue.sv */
// Result group queue and the sequencer that expands a group into result items.
module dpr_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpr_pkg::grp_t        push_grp,
    input  logic [7:0]           push_rdata,
    output logic                 ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [7:0]           tx_char,
    output logic [1:0]           payload_start,
    output logic [10:0]          payload_length,
    output logic [7:0]           read_data,
    output logic                 last
);

    dpr_pkg::q_entry_t entries [dpr_pkg::QDEPTH];

    logic [dpr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dpr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dpr_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [1:0]                 sub_reg, sub_next;

    dpr_pkg::q_entry_t head;
    logic              out_fire;
    logic              pop;

    assign head      = entries[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign pop       = out_fire && last;
    // room for the group now in flight plus one more
    assign ready     = (count_reg + dpr_pkg::QCNT_W'(push)) < dpr_pkg::QCNT_W'(dpr_pkg::QDEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg].grp   <= push_grp;
            entries[wr_ptr_reg].rdata <= push_grp.read_ok ? push_rdata : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + dpr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + dpr_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + dpr_pkg::QCNT_W'(push) - dpr_pkg::QCNT_W'(pop);
        if (pop)
            sub_next = '0;
        else if (out_fire)
            sub_next = sub_reg + 2'd1;
        else
            sub_next = sub_reg;
    end

    // expand the head group
    always_comb
    begin
        kind           = dpr_pkg::KIND_TX;
        tx_char        = 8'h00;
        payload_start  = dpr_pkg::START_NONE;
        payload_length = '0;
        read_data      = 8'h00;
        last           = 1'b0;
        case (head.grp.kind)
            dpr_pkg::GRP_READ:
            begin
                kind      = dpr_pkg::KIND_READ;
                read_data = head.rdata;
                last      = 1'b1;
            end
            dpr_pkg::GRP_NAK:
            begin
                tx_char = dpr_pkg::CH_NAK;
                last    = 1'b1;
            end
            dpr_pkg::GRP_ACK:
            begin
                if (sub_reg == 2'd0)
                begin
                    tx_char = dpr_pkg::CH_ACK;
                end
                else
                begin
                    kind           = dpr_pkg::KIND_READY;
                    payload_length = head.grp.len;
                    last           = 1'b1;
                end
            end
            dpr_pkg::GRP_ACK_SEQ:
            begin
                case (sub_reg)
                    2'd0: tx_char = dpr_pkg::CH_ACK;
                    2'd1: tx_char = head.grp.seq0;
                    2'd2: tx_char = head.grp.seq1;
                    default:
                    begin
                        kind           = dpr_pkg::KIND_READY;
                        payload_start  = dpr_pkg::START_SEQ;
                        payload_length = head.grp.len;
                        last           = 1'b1;
                    end
                endcase
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < dpr_pkg::QCNT_W'(dpr_pkg::QDEPTH)))
        else $error("group pushed into a full queue");

    a_sub_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (sub_reg == 2'd0))
        else $error("sequencer did not restart after last item");

    a_sub_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> (sub_reg == 2'd0))
        else $error("sequencer advanced with no group queued");
`endif

endmodule
